// File: design/dsrt_pkg.sv
// shared types, sizes and codes for the descending sorted record table
package dsrt_pkg;

  // table size and stored key width
  localparam int DEPTH      = 16;
  localparam int SCORE_BITS = 12;

  // field widths of the stream items
  localparam int ID_W    = 16;
  localparam int SCORE_W = 12;
  localparam int RANK_W  = 4;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;
  localparam int CAP_W   = 5;

  // derived widths
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IN_DW   = 32;
  localparam int OUT_DW  = 40;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  // register map, indexed by paddr[2]
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // operation codes carried on tuser
  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_READ   = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // one stored record
  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [SCORE_BITS-1:0] score;
  } rec_t;

  // per-cell control from the top level
  typedef struct packed {
    logic ins;
    logic occ;
  } cell_ctl_t;

endpackage

// File: design/dsrt_cell.sv
// one compare-and-shift cell of the sorted record row
module dsrt_cell (
  input  logic              clk,
  input  dsrt_pkg::cell_ctl_t ctl_i,
  input  dsrt_pkg::rec_t    new_rec_i,
  input  dsrt_pkg::rec_t    prev_rec_i,
  input  logic              prev_ge_i,
  output logic              ge_o,
  output logic              take_new_o,
  output dsrt_pkg::rec_t    rec_o
);
  import dsrt_pkg::*;

  rec_t rec_r;
  rec_t rec_nxt;

  // stays in place when its score ranks at or above the new one
  assign ge_o       = ctl_i.occ && (rec_r.score >= new_rec_i.score);
  assign take_new_o = !ge_o && prev_ge_i;

  // keep, take the new record, or shift down from the left neighbor
  always_comb begin
    rec_nxt = rec_r;
    if (ctl_i.ins && !ge_o) begin
      rec_nxt = take_new_o ? new_rec_i : prev_rec_i;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

  assign rec_o = rec_r;

endmodule

// File: design/descending_sorted_record_table.sv
// top level of the descending sorted record table
// Keeps up to DEPTH records (16-bit id, 12-bit score) in a row of cells in
// descending score order; equal scores stay in arrival order. tuser selects
// insert (0) or read at rank (1). Every request is handled by the cell row,
// where each cell compares its score with the new one and either holds,
// takes the new record or takes its left neighbor's record, and yields one
// result in the output register the next cycle: one request per cycle
// sustained while results are taken. Inserts past the capacity register
// (reset 16) report full; reads at an empty rank report out of range.
module descending_sorted_record_table (
  input  logic                         clk,
  input  logic                         rst_n,
  // request stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [15:0] record_id, [27:16] score, [31:28] rank_index
  input  logic [dsrt_pkg::IN_DW-1:0]   in_tdata,
  // [0] func
  input  logic                         in_tuser,
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [1:0] status, [5:2] position, [21:6] entry_id, [33:22] entry_score, rest 0
  output logic [dsrt_pkg::OUT_DW-1:0]  out_tdata,
  // configuration port
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [dsrt_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [dsrt_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [dsrt_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                         cfg_pready
);
  import dsrt_pkg::*;

  logic [CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0] count_r;
  logic             out_valid_r;
  status_t          status_r;
  logic [POS_W-1:0] pos_r;
  logic [ID_W-1:0]  eid_r;
  logic [SCORE_W-1:0] escore_r;

  // request fields
  logic              acc;
  logic              func;
  logic [ID_W-1:0]   req_id;
  logic [SCORE_W-1:0] req_score;
  logic [RANK_W-1:0] req_rank;
  rec_t              new_rec;

  assign func      = in_tuser;
  assign req_id    = in_tdata[ID_W-1:0];
  assign req_score = in_tdata[ID_W+SCORE_W-1:ID_W];
  assign req_rank  = in_tdata[ID_W+SCORE_W+RANK_W-1:ID_W+SCORE_W];
  assign new_rec   = '{id: req_id, score: req_score[SCORE_BITS-1:0]};

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;

  // full when count reaches the capacity or the row length
  logic full;
  logic do_ins;
  assign full   = (32'(count_r) >= 32'(capacity_r)) || (32'(count_r) >= 32'(DEPTH));
  assign do_ins = acc && (func == FN_INSERT) && !full;

  // cell row
  logic      ge   [DEPTH];
  logic      bnd  [DEPTH];
  rec_t      recs [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.ins = do_ins;
    assign ctl.occ = CNT_W'(k) < count_r;
    dsrt_cell u_cell (
      .clk        (clk),
      .ctl_i      (ctl),
      .new_rec_i  (new_rec),
      .prev_rec_i ((k == 0) ? new_rec : recs[(k == 0) ? 0 : k - 1]),
      .prev_ge_i  ((k == 0) ? 1'b1 : ge[(k == 0) ? 0 : k - 1]),
      .ge_o       (ge[k]),
      .take_new_o (bnd[k]),
      .rec_o      (recs[k])
    );
  end

  // insert rank from the one-hot boundary, read record by one-hot rank select
  logic [POS_W-1:0] ins_pos;
  rec_t             rd_rec;
  always_comb begin
    ins_pos = '0;
    rd_rec  = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (bnd[k]) ins_pos = ins_pos | POS_W'(k);
      if (CNT_W'(req_rank) == CNT_W'(k)) rd_rec = rd_rec | recs[k];
    end
  end

  logic rd_ok;
  assign rd_ok = CNT_W'(req_rank) < count_r;

  // control state: count, capacity, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      capacity_r  <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (do_ins) count_r <= count_r + CNT_W'(1);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr[2] == REG_CAPACITY) begin
        capacity_r <= cfg_pwdata[CAP_W-1:0];
      end
      if (acc) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      eid_r    <= '0;
      escore_r <= '0;
      if (func == FN_INSERT) begin
        status_r <= full ? ST_FULL : ST_DONE;
        pos_r    <= full ? '0 : ins_pos;
      end else begin
        pos_r <= POS_W'(req_rank);
        if (rd_ok) begin
          status_r <= ST_DONE;
          eid_r    <= rd_rec.id;
          escore_r <= SCORE_W'(rd_rec.score);
        end else begin
          status_r <= ST_RANGE;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DW - STAT_W - POS_W - ID_W - SCORE_W)'(0),
                       escore_r, eid_r, pos_r, status_r};

  // register read
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_CAPACITY) ? CFG_DW'(capacity_r) : '0;

endmodule

// File: design/dsrt_checker.sv
// port-level assertions for the descending sorted record table
module dsrt_assertions (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [dsrt_pkg::OUT_DW-1:0] out_tdata
);
  import dsrt_pkg::*;

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // an accepted request always yields a result next cycle
  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("request produced no result");

  // requests are taken whenever the result register is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("stalled with empty result register");

  // non-done results carry zero record fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[STAT_W-1:0] != ST_DONE |->
      out_tdata[OUT_DW-1:STAT_W+POS_W] == '0)
    else $error("refused or out-of-range result carries data");

endmodule

bind descending_sorted_record_table dsrt_assertions u_dsrt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: sim/dsrt_checker.sv
`timescale 1ns / 1ps
// checker for the descending sorted record table: watches the streams, predicts and compares
module dsrt_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  // [15:0] record_id, [27:16] score, [31:28] rank_index
  input  logic [dsrt_pkg::IN_DW-1:0]  in_tdata,
  // [0] func
  input  logic                        in_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  // [1:0] status, [5:2] position, [21:6] entry_id, [33:22] entry_score
  input  logic [dsrt_pkg::OUT_DW-1:0] out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dsrt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [dsrt_pkg::CFG_DW-1:0] cfg_pwdata,
  input  logic [dsrt_pkg::CFG_DW-1:0] cfg_prdata,
  input  logic                        cfg_pready,
  input  logic                        run_done,
  output int                          fail_count,
  output int                          replies_pending,
  output int                          placed_count,
  output int                          refused_count,
  output int                          hit_count,
  output int                          miss_count
);
  import dsrt_pkg::*;

  // one result of the table
  typedef struct {
    status_t               status;
    logic [POS_W-1:0]      position;
    logic [ID_W-1:0]       id;
    logic [SCORE_W-1:0]    score;
  } table_reply_t;

  // shadow copy of the table and its capacity register
  logic [ID_W-1:0]       rank_ids[DEPTH];
  logic [SCORE_BITS-1:0] rank_scores[DEPTH];
  int                    fill;
  logic [CAP_W-1:0]      cap_reg;

  table_reply_t table_replies_q[$];
  table_reply_t want;
  table_reply_t got;
  bit           leftover_flagged;

  initial begin
    fail_count       = 0;
    replies_pending  = 0;
    placed_count     = 0;
    refused_count    = 0;
    hit_count        = 0;
    miss_count       = 0;
    fill             = 0;
    cap_reg          = CAP_RESET;
    leftover_flagged = 0;
  end

  // one line per mismatch
  task automatic report(input string what);
    fail_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // insert or read on the shadow table, returning the result it gives
  function automatic table_reply_t table_apply(input logic fn,
      input logic [ID_W-1:0] id, input logic [SCORE_W-1:0] score,
      input logic [RANK_W-1:0] rank);
    table_reply_t r;
    int           limit;
    int           slot;
    int           k;
    r.status   = ST_DONE;
    r.position = '0;
    r.id       = '0;
    r.score    = '0;
    limit = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
    if (fn == FN_INSERT) begin
      if (fill >= limit || fill >= DEPTH) begin
        r.status = ST_FULL;
        refused_count++;
      end else begin
        // new record goes after every score greater or equal
        slot = 0;
        while (slot < fill && rank_scores[slot] >= score[SCORE_BITS-1:0]) slot++;
        for (k = fill; k > slot; k--) begin
          rank_ids[k]    = rank_ids[k-1];
          rank_scores[k] = rank_scores[k-1];
        end
        rank_ids[slot]    = id;
        rank_scores[slot] = score[SCORE_BITS-1:0];
        fill++;
        r.position = slot[POS_W-1:0];
        placed_count++;
      end
    end else begin
      r.position = rank;
      if (int'(rank) < fill) begin
        r.id    = rank_ids[rank];
        r.score = rank_scores[rank];
        hit_count++;
      end else begin
        r.status = ST_RANGE;
        miss_count++;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fill    = 0;
      cap_reg = CAP_RESET;
      table_replies_q.delete();
    end else begin
      // register write and read-back
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr[2] == REG_CAPACITY) begin
        if (cfg_pwrite) begin
          cap_reg = cfg_pwdata[CAP_W-1:0];
        end else if (cfg_prdata !== CFG_DW'(cap_reg)) begin
          report($sformatf("capacity read 0x%0h, held 0x%0h", cfg_prdata, cap_reg));
        end
      end
      // result side
      if (out_tvalid && out_tready) begin
        got.status   = status_t'(out_tdata[1:0]);
        got.position = out_tdata[5:2];
        got.id       = out_tdata[21:6];
        got.score    = out_tdata[33:22];
        if (table_replies_q.size() == 0) begin
          report($sformatf("result with nothing pending, tdata 0x%0h", out_tdata));
        end else begin
          want = table_replies_q.pop_front();
          if (got.status !== want.status)
            report($sformatf("status %0d, wanted %0d", got.status, want.status));
          if (got.position !== want.position)
            report($sformatf("position %0d, wanted %0d", got.position, want.position));
          if (got.id !== want.id)
            report($sformatf("entry_id 0x%0h, wanted 0x%0h", got.id, want.id));
          if (got.score !== want.score)
            report($sformatf("entry_score 0x%0h, wanted 0x%0h", got.score, want.score));
          if (out_tdata[OUT_DW-1:34] !== '0)
            report($sformatf("pad bits not zero, tdata 0x%0h", out_tdata));
        end
      end
      // request side
      if (in_tvalid && in_tready) begin
        table_replies_q.push_back(table_apply(in_tuser, in_tdata[15:0],
                                              in_tdata[27:16], in_tdata[31:28]));
      end
      // results still owed once the run has drained
      if (run_done && !leftover_flagged && table_replies_q.size() != 0) begin
        leftover_flagged = 1;
        report($sformatf("%0d results never arrived", table_replies_q.size()));
      end
    end
    replies_pending = table_replies_q.size();
  end

endmodule

// File: sim/tb_descending_sorted_record_table.sv
`timescale 1ns / 1ps
// testbench top for the descending sorted record table: stimulus, pacing and verdict
module tb_descending_sorted_record_table;
  import dsrt_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;
  logic              run_done;

  int fail_count;
  int replies_pending;
  int placed_count;
  int refused_count;
  int hit_count;
  int miss_count;
  int sent;
  int burst_left;
  bit squeeze_req;
  bit squeeze_done;

  // capacity for each random phase: grow, saturate, lower, shut, reopen
  int phase_caps[7] = '{7, 31, 16, 17, 0, 5, 16};

  descending_sorted_record_table i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  dsrt_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .run_done        (run_done),
    .fail_count      (fail_count),
    .replies_pending (replies_pending),
    .placed_count    (placed_count),
    .refused_count   (refused_count),
    .hit_count       (hit_count),
    .miss_count      (miss_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop if the run hangs
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // offer one request and hold it until taken
  task automatic send_request(input logic fn, input logic [ID_W-1:0] id,
      input logic [SCORE_W-1:0] score, input logic [RANK_W-1:0] rank);
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {rank, score, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // bursts of random length, mostly followed by a short gap
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // stop offering and wait for every owed result, bounded
  task automatic settle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (replies_pending != 0 && waited < 5000);
  endtask

  // one apb transfer to the capacity register, then the bus returns to idle
  task automatic apb_access(input logic wr, input logic [CFG_DW-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {REG_CAPACITY, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // change capacity while idle and read it back
  task automatic set_capacity(input int value);
    settle();
    apb_access(1'b1, CFG_DW'(value));
    apb_access(1'b0, '0);
  endtask

  // random request; scores often drawn from a few values to force ties
  task automatic random_request(input int ins_pct);
    logic               fn;
    logic [SCORE_W-1:0] sc;
    fn = ($urandom_range(0, 99) < ins_pct) ? FN_INSERT : FN_READ;
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 3))
        0:       sc = '0;
        1:       sc = '1;
        2:       sc = 12'h800;
        default: sc = 12'h7FF;
      endcase
    end else begin
      sc = SCORE_W'($urandom);
    end
    send_request(fn, ID_W'($urandom), sc, RANK_W'($urandom_range(0, 15)));
  endtask

  // receiver: ready stretches, random stalls, fixed patterns, one long hold-off
  initial begin : receiver
    int mode;
    int span;
    int k;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_tready <= 1'b0;
        repeat (96) @(posedge clk);
        squeeze_done = 1;
      end
      mode = $urandom_range(0, 3);
      span = (mode == 3) ? $urandom_range(2, 10) : $urandom_range(10, 60);
      for (k = 0; k < span; k++) begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 9) < 7);
          2:       out_tready <= (k % 3 == 0);
          default: out_tready <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int p;
    int n;
    sent         = 0;
    burst_left   = 0;
    squeeze_req  = 0;
    squeeze_done = 0;
    rst_n        <= 1'b0;
    run_done     <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= FN_INSERT;
    cfg_psel     <= 1'b0;
    cfg_penable  <= 1'b0;
    cfg_pwrite   <= 1'b0;
    cfg_paddr    <= '0;
    cfg_pwdata   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // capacity zero: every insert refused, empty table reads out of range
    set_capacity(0);
    send_request(FN_INSERT, 16'hFFFF, 12'hFFF, 4'hF);
    send_request(FN_READ, 16'hFFFF, 12'hFFF, 4'h0);
    send_request(FN_READ, 16'h0000, 12'h000, 4'hF);

    // capacity one: single slot, then full
    set_capacity(1);
    send_request(FN_INSERT, 16'h0000, 12'h000, 4'h0);
    send_request(FN_INSERT, 16'hFFFF, 12'hFFF, 4'hF);
    send_request(FN_READ, 16'h0000, 12'h000, 4'h0);
    send_request(FN_READ, 16'hFFFF, 12'hFFF, 4'h1);

    // equal scores keep arrival order, lowest score goes last
    set_capacity(4);
    send_request(FN_INSERT, 16'h1234, 12'hFFF, 4'h5);
    send_request(FN_INSERT, 16'hABCD, 12'hFFF, 4'hA);
    send_request(FN_INSERT, 16'hFFFF, 12'h000, 4'hF);
    for (n = 0; n < 5; n++) send_request(FN_READ, 16'hFFFF, 12'hFFF, RANK_W'(n));

    // capacity lowered below the fill: inserts refused, records still readable
    set_capacity(2);
    send_request(FN_INSERT, 16'h5555, 12'hAAA, 4'h0);
    send_request(FN_READ, 16'h0000, 12'h000, 4'h3);

    // random phases across capacity settings
    for (p = 0; p < 7; p++) begin
      set_capacity(phase_caps[p]);
      squeeze_req = 1;
      n = $urandom_range(20, 70);
      repeat (285) begin
        pace_sender();
        random_request(n);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);

    $display("%0d requests over capacities 0 to 31: %0d inserts placed, %0d refused full",
             sent, placed_count, refused_count);
    $display("%0d reads found a record, %0d read an empty rank; one long output hold-off",
             hit_count, miss_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
design/dsrt_pkg.sv
design/dsrt_cell.sv
design/descending_sorted_record_table.sv
design/dsrt_checker.sv
sim/dsrt_checker.sv
sim/tb_descending_sorted_record_table.sv
